// ===== sv/mpid_pkg.sv =====
// ----------------------------------------------------------------------------
// mpid_pkg
// Shared types and constants of the multichannel PID speed controller:
// register indexes, reset values, the settings bundle and the per-channel
// state word kept in the state memory.
// ----------------------------------------------------------------------------
package mpid_pkg;

  // Fraction bits of the gains, the integral and the sum before truncation.
  localparam int FRAC_BITS = 12;
  // Speed error width: the difference of two 16-bit signed speeds.
  localparam int ERR_W = 17;
  localparam int INT_W = 28;
  localparam int DRV_W = 16;

  localparam logic [15:0] RST_GAIN_P       = 16'd14336;
  localparam logic [15:0] RST_GAIN_I       = 16'd205;
  localparam logic [15:0] RST_GAIN_D       = 16'd1229;
  localparam logic [14:0] RST_OUTPUT_LIMIT = 15'd16384;
  localparam logic [14:0] RST_INT_BOUND    = 15'd10000;
  localparam logic [15:0] RST_DEAD_ZONE    = 16'd10;

  typedef enum logic [2:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_OUTPUT_LIMIT   = 3'd3,
    REG_INTEGRAL_BOUND = 3'd4,
    REG_DEAD_ZONE      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [14:0] output_limit;
    logic [14:0] integral_bound;
    logic [15:0] dead_zone;
  } cfg_t;

  // One entry of the state memory.
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [INT_W-1:0] integ;
    logic signed [DRV_W-1:0] held;
  } chan_state_t;

  // Pipeline control handed from the sequencer to the datapath.
  typedef struct packed {
    logic adv;
    logic s3_inr;
  } pipe_ctl_t;

endpackage

// ===== sv/mpid_ram.sv =====
// ----------------------------------------------------------------------------
// mpid_ram
// Generic single write port, single read port RAM with a registered read.
// The read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module mpid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/mpid_dp.sv =====
// ----------------------------------------------------------------------------
// mpid_dp
// Arithmetic pipeline of the controller: error, products, integral update
// with clamp, output sum with clamp and truncation, and the new state word.
// ----------------------------------------------------------------------------
module mpid_dp (
  input  logic                              clk,
  input  mpid_pkg::pipe_ctl_t               ctl,
  input  mpid_pkg::cfg_t                    cfg,
  input  logic signed [15:0]                target_speed,
  input  logic signed [15:0]                measured_speed,
  input  mpid_pkg::chan_state_t             rd_state,
  input  logic                              rd_vld,
  output mpid_pkg::chan_state_t             wr_state,
  output logic signed [15:0]                drive
);
  import mpid_pkg::*;

  // Stage 1: error, state from memory arrives.
  logic signed [ERR_W-1:0] s1_err;
  // Stage 2: products and old state.
  logic signed [ERR_W-1:0] s2_err;
  logic                    s2_hold;
  logic signed [33:0]      s2_p;
  logic signed [33:0]      s2_i;
  logic signed [34:0]      s2_d;
  logic signed [INT_W-1:0] s2_int;
  logic signed [DRV_W-1:0] s2_held;
  // Stage 3: new integral and P+D sum.
  logic signed [ERR_W-1:0] s3_err;
  logic                    s3_hold;
  logic signed [35:0]      s3_pd;
  logic signed [INT_W-1:0] s3_int;
  logic signed [DRV_W-1:0] s3_held;

  chan_state_t             old_st;
  logic signed [ERR_W:0]   diff;
  logic [ERR_W-1:0]        mag;
  logic                    hold;
  logic signed [33:0]      prod_p;
  logic signed [33:0]      prod_i;
  logic signed [34:0]      prod_d;

  logic signed [34:0]      ib;
  logic signed [34:0]      isum;
  logic signed [34:0]      iclamp;
  logic signed [INT_W-1:0] int_new;
  logic signed [35:0]      pd;

  logic signed [36:0]      ol;
  logic signed [36:0]      acc;
  logic signed [36:0]      acc_c;
  logic signed [36:0]      rnd;
  logic signed [36:0]      quo;
  logic signed [DRV_W-1:0] drive_calc;

  always_comb begin
    old_st = rd_vld ? rd_state : '0;
    diff   = {s1_err[ERR_W-1], s1_err} - {old_st.err[ERR_W-1], old_st.err};
    mag    = s1_err[ERR_W-1] ? ERR_W'(-s1_err) : ERR_W'(s1_err);
    hold   = mag < {1'b0, cfg.dead_zone};
    prod_p = $signed({1'b0, cfg.gain_p}) * s1_err;
    prod_i = $signed({1'b0, cfg.gain_i}) * s1_err;
    prod_d = $signed({1'b0, cfg.gain_d}) * diff;
  end

  always_comb begin
    ib   = $signed({8'd0, cfg.integral_bound, 12'd0});
    isum = 35'(s2_int) + 35'(s2_i);
    if (isum > ib) begin
      iclamp = ib;
    end else if (isum < -ib) begin
      iclamp = -ib;
    end else begin
      iclamp = isum;
    end
    int_new = s2_hold ? s2_int : INT_W'(iclamp);
    pd      = 36'(s2_p) + 36'(s2_d);
  end

  always_comb begin
    ol  = $signed({10'd0, cfg.output_limit, 12'd0});
    acc = 37'(s3_pd) + 37'(s3_int);
    if (acc > ol) begin
      acc_c = ol;
    end else if (acc < -ol) begin
      acc_c = -ol;
    end else begin
      acc_c = acc;
    end
    // Truncate toward zero: bias negative sums before the arithmetic shift.
    rnd        = acc_c[36] ? acc_c + 37'((1 << FRAC_BITS) - 1) : acc_c;
    quo        = rnd >>> FRAC_BITS;
    drive_calc = s3_hold ? s3_held : quo[DRV_W-1:0];
    wr_state.err   = s3_err;
    wr_state.integ = s3_int;
    wr_state.held  = drive_calc;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s1_err  <= $signed({target_speed[15], target_speed})
               - $signed({measured_speed[15], measured_speed});
      s2_err  <= s1_err;
      s2_hold <= hold;
      s2_p    <= prod_p;
      s2_i    <= prod_i;
      s2_d    <= prod_d;
      s2_int  <= old_st.integ;
      s2_held <= old_st.held;
      s3_err  <= s2_err;
      s3_hold <= s2_hold;
      s3_pd   <= pd;
      s3_int  <= int_new;
      s3_held <= s2_held;
      drive   <= ctl.s3_inr ? drive_calc : '0;
    end
  end

endmodule

// ===== sv/multichannel_pid_speed_controller_core.sv =====
// Path: a word accepted into stage s1 moves on through s2 and s3 and is then registered
// on the output. Throughput: one word per cycle while the output is not stalled and no
// channel repeats within any four successive words. A word for a channel still in the
// three internal stages waits, so that the read, update and write-back loop through the
// state memory is closed before the channel is read again.
// Reset: settings return to defaults and all channel state reads as zero at once.
// ----------------------------------------------------------------------------
// multichannel_pid_speed_controller_core
// Multichannel PID speed controller with dead zone, integral clamp and
// output clamp. Per-channel state (last error, integral, held drive) lives
// in one synchronous RAM that is read at acceptance and written back when
// the result leaves the last stage.
// ----------------------------------------------------------------------------
module multichannel_pid_speed_controller_core #(
  parameter int CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         channel,
  input  logic signed [15:0] target_speed,
  input  logic signed [15:0] measured_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         channel_out,
  output logic signed [15:0] drive,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import mpid_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [6:0] NCH = 7'(CHANNELS);

  cfg_t cfg;

  // Pipeline occupancy and channel tags.
  logic       s1_v, s2_v, s3_v;
  logic [2:0] s1_ch, s2_ch, s3_ch;
  logic       s1_inr, s2_inr, s3_inr;

  logic       adv;
  logic       conflict;
  logic       acc_in;
  logic       in_inr;
  logic       we;

  logic [AW+2:0] rd_ext;
  logic [AW+2:0] wr_ext;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  // Entry valid bits: an entry not written since reset reads as zero state.
  logic [CHANNELS-1:0] ent_vld;
  logic                rd_vld;

  chan_state_t rd_state;
  chan_state_t wr_state;
  pipe_ctl_t   ctl;

  // The whole pipeline moves together whenever the output register is free.
  // A new word is held off while its channel is still in flight, so the
  // state read at acceptance always sees every earlier update of it.
  always_comb begin
    adv      = !out_valid || out_ready;
    conflict = (s1_v && s1_ch == channel) || (s2_v && s2_ch == channel)
            || (s3_v && s3_ch == channel);
    in_ready = adv && !conflict;
    acc_in   = in_valid && in_ready;
    in_inr   = {4'd0, channel} < NCH;
    we       = adv && s3_v && s3_inr;
    rd_ext   = {{AW{1'b0}}, channel};
    wr_ext   = {{AW{1'b0}}, s3_ch};
    raddr    = rd_ext[AW-1:0];
    waddr    = wr_ext[AW-1:0];
    cfg_ready = 1'b1;
    ctl.adv    = adv;
    ctl.s3_inr = s3_inr;
  end

  // Settings registers. Indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= RST_GAIN_P;
      cfg.gain_i         <= RST_GAIN_I;
      cfg.gain_d         <= RST_GAIN_D;
      cfg.output_limit   <= RST_OUTPUT_LIMIT;
      cfg.integral_bound <= RST_INT_BOUND;
      cfg.dead_zone      <= RST_DEAD_ZONE;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_GAIN_P:         cfg.gain_p         <= cfg_data;
        REG_GAIN_I:         cfg.gain_i         <= cfg_data;
        REG_GAIN_D:         cfg.gain_d         <= cfg_data;
        REG_OUTPUT_LIMIT:   cfg.output_limit   <= cfg_data[14:0];
        REG_INTEGRAL_BOUND: cfg.integral_bound <= cfg_data[14:0];
        REG_DEAD_ZONE:      cfg.dead_zone      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid flags and entry valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
      ent_vld   <= '0;
    end else begin
      if (adv) begin
        s1_v      <= acc_in;
        s2_v      <= s1_v;
        s3_v      <= s2_v;
        out_valid <= s3_v;
      end
      if (we) begin
        ent_vld[waddr] <= 1'b1;
      end
    end
  end

  // Channel tags travel beside the datapath.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ch       <= channel;
      s1_inr      <= in_inr;
      s2_ch       <= s1_ch;
      s2_inr      <= s1_inr;
      s3_ch       <= s2_ch;
      s3_inr      <= s2_inr;
      channel_out <= s3_ch;
    end
    if (acc_in) begin
      rd_vld <= in_inr && ent_vld[raddr];
    end
  end

  mpid_ram #(
    .WIDTH ($bits(chan_state_t)),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_state),
    .re    (acc_in),
    .raddr (raddr),
    .rdata (rd_state)
  );

  mpid_dp u_dp (
    .clk            (clk),
    .ctl            (ctl),
    .cfg            (cfg),
    .target_speed   (target_speed),
    .measured_speed (measured_speed),
    .rd_state       (rd_state),
    .rd_vld         (rd_vld),
    .wr_state       (wr_state),
    .drive          (drive)
  );

  // A write-back never targets the channel being read at the same edge.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (we && acc_in) |-> (s3_ch != channel))
    else $error("state write-back overlaps a read of the same channel");

  // A channel outside the configured count always yields a zero drive.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ({4'd0, channel_out} >= NCH)) |-> (drive == 16'sd0))
    else $error("out-of-range channel produced a nonzero drive");

  // A stalled output freezes the whole pipeline.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable({s1_v, s2_v, s3_v}))
    else $error("pipeline moved while the output was stalled");

  // Every written entry is marked valid afterwards.
  a_vld_set: assert property (@(posedge clk) disable iff (rst)
    we |=> ent_vld[$past(waddr)])
    else $error("written state entry not marked valid");

endmodule

// ===== tb/mpid_drive_checker.sv =====
// ----------------------------------------------------------------------------
// mpid_drive_checker
// Watches the item, result and register channels of the PID speed controller,
// keeps its own copy of the settings and the per-channel loop state, predicts
// the drive word for each accepted item and compares every accepted result
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mpid_drive_checker #(
  parameter int CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         channel,
  input  logic signed [15:0] target_speed,
  input  logic signed [15:0] measured_speed,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         channel_out,
  input  logic signed [15:0] drive,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import mpid_pkg::*;

  localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;

  typedef struct packed {
    logic [2:0]         ch;
    logic signed [15:0] drive;
  } drive_word_t;

  logic [15:0] gain_p, gain_i, gain_d, dead_zone;
  logic [14:0] output_limit, integral_bound;

  logic signed [17:0] cur_err  [CHANNELS];
  logic signed [17:0] prev_err [CHANNELS];
  logic signed [27:0] integ    [CHANNELS];
  logic signed [15:0] held     [CHANNELS];

  drive_word_t drive_expected[$];
  drive_word_t want;
  int          mism = 0;

  function automatic longint clamp_sym(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Steps one channel's loop and returns the drive word it should produce.
  function automatic drive_word_t predict_drive(input logic [2:0] ch,
                                                input logic signed [15:0] tgt,
                                                input logic signed [15:0] meas);
    drive_word_t r;
    longint      e, mag, isum, acc;
    r.ch    = ch;
    r.drive = '0;
    if (ch < CHANNELS) begin
      e            = longint'(tgt) - longint'(meas);
      prev_err[ch] = cur_err[ch];
      cur_err[ch]  = e[17:0];
      mag          = (e < 0) ? -e : e;
      if (mag < longint'(dead_zone)) begin
        // Inside the dead zone the last drive is repeated, integral frozen.
        r.drive = held[ch];
      end else begin
        isum      = clamp_sym(longint'(integ[ch]) + longint'(gain_i) * e,
                              longint'(integral_bound) * FRAC_ONE);
        integ[ch] = isum[27:0];
        acc       = longint'(gain_p) * e + isum
                  + longint'(gain_d) * (e - longint'(prev_err[ch]));
        acc       = clamp_sym(acc, longint'(output_limit) * FRAC_ONE) / FRAC_ONE;
        held[ch]  = acc[15:0];
        r.drive   = acc[15:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gain_p         = RST_GAIN_P;
      gain_i         = RST_GAIN_I;
      gain_d         = RST_GAIN_D;
      output_limit   = RST_OUTPUT_LIMIT;
      integral_bound = RST_INT_BOUND;
      dead_zone      = RST_DEAD_ZONE;
      for (int i = 0; i < CHANNELS; i++) begin
        cur_err[i]  = '0;
        prev_err[i] = '0;
        integ[i]    = '0;
        held[i]     = '0;
      end
      drive_expected.delete();
    end else begin
      // Results first: a word leaving now can never belong to an item
      // accepted at this same edge.
      if (out_valid && out_ready) begin
        if (drive_expected.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("unexpected drive word: ch %0d drive %0d", channel_out, drive);
        end else begin
          want = drive_expected.pop_front();
          if (want.ch !== channel_out || want.drive !== drive) begin
            mism++;
            if (mism <= 10)
              $display("drive mismatch: expected ch %0d drive %0d, got ch %0d drive %0d",
                       want.ch, want.drive, channel_out, drive);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P:         gain_p         = cfg_data;
          REG_GAIN_I:         gain_i         = cfg_data;
          REG_GAIN_D:         gain_d         = cfg_data;
          REG_OUTPUT_LIMIT:   output_limit   = cfg_data[14:0];
          REG_INTEGRAL_BOUND: integral_bound = cfg_data[14:0];
          REG_DEAD_ZONE:      dead_zone      = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        drive_expected.push_back(predict_drive(channel, target_speed, measured_speed));
    end
    pending    <= drive_expected.size();
    fail_count <= mism;
  end

endmodule

// ===== tb/tb_multichannel_pid_speed_controller_core.sv =====
// ----------------------------------------------------------------------------
// tb_multichannel_pid_speed_controller_core
// Drives speed words into the multichannel PID controller under several
// register settings, with random gaps on both sides and one long output
// stall, while a checker beside the block predicts and compares every drive.
// ----------------------------------------------------------------------------
module tb_multichannel_pid_speed_controller_core;
  import mpid_pkg::*;

  localparam int CHANNELS       = 8;
  localparam int CLK_PERIOD     = 20;
  localparam int TIMEOUT_CYCLES = 200000;
  // Cycles the block may still need after the last word has come out.
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 200;

  localparam logic signed [15:0] SPEED_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SPEED_MIN = 16'sh8000;
  localparam logic [15:0]        Q12_ONE   = 16'd4096;
  localparam logic [15:0]        ALL_ONES  = 16'hFFFF;
  localparam logic [15:0]        LIMIT_MAX = 16'h7FFF;
  // Register indexes that map to no register; writes there must be ignored.
  localparam logic [2:0]         UNMAPPED_IDX_LO = 3'd6;
  localparam logic [2:0]         UNMAPPED_IDX_HI = 3'd7;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         channel = '0;
  logic signed [15:0] target_speed = '0;
  logic signed [15:0] measured_speed = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         channel_out;
  logic signed [15:0] drive;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  int         fails;
  int         pending;
  // Random gaps on both sides are switched off for the quiet stretch.
  bit         idle_on = 1'b1;
  // The stimulus asks for a long output stall by bumping hold_asked; the
  // receiver counts out the stall itself.
  int         hold_asked = 0;
  int         hold_taken = 0;
  int         hold_left = 0;
  logic [2:0] last_ch = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  multichannel_pid_speed_controller_core #(
    .CHANNELS(CHANNELS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .channel       (channel),
    .target_speed  (target_speed),
    .measured_speed(measured_speed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_out   (channel_out),
    .drive         (drive),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  mpid_drive_checker #(
    .CHANNELS(CHANNELS)
  ) drive_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .channel       (channel),
    .target_speed  (target_speed),
    .measured_speed(measured_speed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_out   (channel_out),
    .drive         (drive),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fails),
    .pending       (pending)
  );

  // Receiver side. Each cycle it either counts down a requested long stall,
  // starts one when the stimulus has asked for it, or picks ready at random.
  // While the long stall runs the three internal stages fill up and the
  // block has to push back on the sender.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken = hold_taken + 1;
      hold_left  = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_on || ($urandom_range(99) >= 25);
    end
  end

  // One register write. The valid is left high so that a following write
  // can reuse it; load_settings lowers it after the last one.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes all six registers in index order.
  task automatic load_settings(input logic [15:0] gp, input logic [15:0] gi,
                               input logic [15:0] gd, input logic [15:0] ol,
                               input logic [15:0] ib, input logic [15:0] dz);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_OUTPUT_LIMIT, ol);
    write_reg(REG_INTEGRAL_BOUND, ib);
    write_reg(REG_DEAD_ZONE, dz);
    cfg_valid <= 1'b0;
  endtask

  // Offers one speed word. A gap, when one is drawn, lowers valid for whole
  // cycles before the word goes up; the valid is never dropped and raised in
  // the same step, so back-to-back words keep it high throughout.
  task automatic send_item(input logic [2:0] ch, input logic signed [15:0] tgt,
                           input logic signed [15:0] meas);
    while (idle_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    channel        <= ch;
    target_speed   <= tgt;
    measured_speed <= meas;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Closes a burst and waits until every predicted drive word has come out,
  // then lets the pipeline settle so that registers may be written safely.
  // The first edge is taken before looking at the count, since the count
  // is a registered copy of the checker's queue size.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random word. About 40 percent of the time the same channel is hit again,
  // which exercises the back-pressure for a channel still in flight. The
  // speeds come in three flavors: measured close to target (dead zone and
  // integral build-up), moderate speeds, and the full 16-bit range.
  task automatic send_random_item();
    int                 kind;
    logic [2:0]         ch;
    logic signed [15:0] tgt, meas;
    kind = $urandom_range(99);
    if ($urandom_range(99) < 40)
      ch = last_ch;
    else
      ch = 3'($urandom_range(CHANNELS - 1));
    if (kind < 40) begin
      tgt  = 16'($urandom);
      meas = tgt - 16'($urandom_range(64)) + 16'd32;
    end else if (kind < 70) begin
      tgt  = 16'($urandom_range(4000)) - 16'd2000;
      meas = 16'($urandom_range(4000)) - 16'd2000;
    end else begin
      tgt  = 16'($urandom);
      meas = 16'($urandom);
    end
    last_ch = ch;
    send_item(ch, tgt, meas);
  endtask

  // Gains are often zero or full scale so that the clamps get hit, and
  // otherwise mostly modest so that the loop shows real dynamics.
  function automatic logic [15:0] pick_gain();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 30) return ALL_ONES;
    if (r < 75) return 16'($urandom_range(8191));
    return 16'($urandom);
  endfunction

  // Limits are 15-bit registers; a full 16-bit value now and then makes
  // sure the top data bit is dropped.
  function automatic logic [15:0] pick_limit();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 30) return LIMIT_MAX;
    if (r < 40) return 16'($urandom);
    return 16'($urandom_range(20000, 1));
  endfunction

  function automatic logic [15:0] pick_zone();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 25) return ALL_ONES;
    return 16'($urandom_range(300));
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero error, both extremes of error, the dead zone
    // edges from both sides, a repeated error on one channel back to back,
    // and the remaining channels at the speed extremes.
    send_item(3'd0, 16'sd0, 16'sd0);
    send_item(3'd1, SPEED_MAX, SPEED_MIN);
    send_item(3'd1, SPEED_MIN, SPEED_MAX);
    send_item(3'd2, 16'sd100, 16'sd91);
    send_item(3'd2, 16'sd100, 16'sd90);
    send_item(3'd2, -16'sd100, -16'sd90);
    send_item(3'd2, 16'sd0, 16'sd9);
    repeat (5) send_item(3'd3, 16'sd1000, 16'sd0);
    send_item(3'd7, SPEED_MAX, 16'sd0);
    send_item(3'd5, SPEED_MIN, 16'sd0);
    send_item(3'd6, 16'sd0, SPEED_MIN);
    send_item(3'd4, 16'sd0, SPEED_MAX);
    drain();

    // Everything at full scale and no dead zone: a zero error is computed
    // rather than held, and alternating extremes drive both clamps.
    load_settings(ALL_ONES, ALL_ONES, ALL_ONES, LIMIT_MAX, LIMIT_MAX, '0);
    send_item(3'd0, 16'sd0, 16'sd0);
    send_item(3'd0, SPEED_MAX, SPEED_MIN);
    send_item(3'd0, SPEED_MAX, SPEED_MIN);
    send_item(3'd0, SPEED_MIN, SPEED_MAX);
    send_item(3'd1, 16'sd1, 16'sd0);
    send_item(3'd1, 16'sd1, 16'sd0);
    drain();

    // Zero limits clamp everything to zero, and the widest dead zone lets
    // only the largest error magnitude through.
    load_settings(Q12_ONE, Q12_ONE, Q12_ONE, '0, '0, ALL_ONES);
    send_item(3'd0, SPEED_MAX, SPEED_MIN);
    send_item(3'd0, SPEED_MAX, -16'sd32767);
    send_item(3'd1, SPEED_MIN, SPEED_MAX);
    drain();

    // Random phases. The first keeps the reset gains, the second runs with
    // no gaps at all, the fourth carries the long output stall.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(3) == 0)
        write_reg(($urandom_range(1) == 0) ? UNMAPPED_IDX_LO : UNMAPPED_IDX_HI,
                  16'($urandom));
      if (ph == 0 || $urandom_range(9) == 0)
        load_settings(RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, 16'(RST_OUTPUT_LIMIT),
                      16'(RST_INT_BOUND), RST_DEAD_ZONE);
      else
        load_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit(),
                      pick_limit(), pick_zone());
      idle_on = (ph != 1);
      if (ph == 3)
        hold_asked = hold_asked + 1;
      repeat (PHASE_ITEMS) send_random_item();
      drain();
    end
    idle_on = 1'b1;

    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

endmodule
